FILE: hdl/rgb_histogram_equalizer_top_defines.svh
// Assertion macros for the equalizer top level.
`ifndef RGB_HISTOGRAM_EQUALIZER_TOP_DEFINES_SVH
`define RGB_HISTOGRAM_EQUALIZER_TOP_DEFINES_SVH

// Implication checked on every edge outside reset.
`define RHE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define RHE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/rhe_pkg.sv
// Shared types and constants for the histogram equalizer.
package rhe_pkg;
   localparam int BinCount = 256;
   localparam int BinBits  = 8;
   localparam int PixBits  = 8;

   typedef enum logic [1:0] {
      OP_COUNT = 2'd0,
      OP_BUILD = 2'd1,
      OP_MAP   = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // Request from the controller to the divider.
   typedef struct packed {
      logic        start;
      logic [39:0] cum;
      logic [31:0] total;
   } div_req_type;

   typedef struct packed {
      logic       done;
      logic [7:0] value;
   } div_rsp_type;
endpackage

FILE: hdl/rhe_divider.sv
// Serial restoring divider: min(255, floor((512*cum + total) / (2*total))).
module rhe_divider (
   input  logic                clock,
   input  logic                reset,
   input  rhe_pkg::div_req_type req,
   output rhe_pkg::div_rsp_type rsp
);
   import rhe_pkg::*;
   // Numerator < 2^50; keep the whole quotient so large ones saturate.
   localparam int NumBits = 50;
   localparam int DenBits = 33;
   localparam int QBits   = NumBits;

   logic [DenBits:0]    rem_ff, rem_in;
   logic [NumBits-1:0]  num_ff, num_in;
   logic [DenBits-1:0]  den_ff, den_in;
   logic [QBits-1:0]    q_ff, q_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DenBits:0]    trial;
   logic [DenBits:0]    shifted;

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[DenBits-1:0], num_ff[NumBits-1]};
      trial   = shifted - {1'b0, den_ff};
      if (req.start) begin
         rem_in  = '0;
         num_in  = {1'b0, req.cum, 9'd0} + {18'd0, req.total};
         den_in  = {req.total, 1'b0};
         q_in    = '0;
         cnt_in  = 6'(NumBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NumBits-2:0], 1'b0};
         if (!trial[DenBits]) begin
            rem_in = trial;
            q_in   = {q_ff[QBits-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in   = {q_ff[QBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = (q_ff > QBits'(255)) ? 8'd255 : q_ff[7:0];
endmodule

FILE: hdl/rgb_histogram_equalizer_top.sv
// Top level: histogram memory, mapping table memory and op sequencer.
// Count: read, modify, write back one bin per channel for each item.
// Map: a map holds in its read state while a result waits.
// Clear: sweeps every bin to zero. Build: per bin one read and one serial division.
// Reset is synchronous; after it the histograms are swept to zero before the
// first item is accepted.
module rgb_histogram_equalizer_top #(
   parameter int CHANNELS   = 3,
   parameter int COUNT_BITS = 23
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_blue_in,
   input  logic [7:0] req_green_in,
   input  logic [7:0] req_red_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_blue_out,
   output logic [7:0] rsp_green_out,
   output logic [7:0] rsp_red_out
);
   import rhe_pkg::*;
   `include "rgb_histogram_equalizer_top_defines.svh"

   localparam int ChBits = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [COUNT_BITS-1:0] CntMax = '1;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_CREAD = 8'b0000_0010,
      ST_CWR   = 8'b0000_0100,
      ST_MREAD = 8'b0000_1000,
      ST_CLEAR = 8'b0001_0000,
      ST_BREAD = 8'b0010_0000,
      ST_BDIV  = 8'b0100_0000,
      ST_BWAIT = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0] hist_mem [CHANNELS][BinCount];
   logic [7:0]            map_mem  [CHANNELS][BinCount];
   logic [COUNT_BITS-1:0] hist_rd_ff [CHANNELS];
   logic [7:0]            map_rd_ff  [CHANNELS];

   logic [7:0]            pix_ff [CHANNELS];
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [BinBits-1:0]    bin_ff, bin_in;
   logic [ChBits-1:0]     ch_ff, ch_in;
   logic [39:0]           cum_ff, cum_in;
   logic                  rsp_valid_ff;
   logic [7:0]            out_ff [3];
   logic [7:0]            pass_ff [3];
   logic [7:0]            in_pix [3];
   logic                  accept;
   logic                  map_ready;
   logic [COUNT_BITS-1:0] bread;
   div_req_type           dreq;
   div_rsp_type           drsp;

   assign in_pix[0] = req_blue_in;
   assign in_pix[1] = req_green_in;
   assign in_pix[2] = req_red_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Histogram memories: one read port, one write port each.
   always_ff @(posedge clock) begin
      for (int c = 0; c < CHANNELS; c++) begin
         if (state_ff == ST_CLEAR) begin
            hist_mem[c][bin_ff] <= '0;
         end else if (state_ff == ST_CWR) begin
            hist_mem[c][pix_ff[c]] <= (hist_rd_ff[c] == CntMax) ? CntMax
                                      : hist_rd_ff[c] + 1'b1;
         end
         if (accept) begin
            hist_rd_ff[c] <= hist_mem[c][(c < 3) ? in_pix[c] : 8'd0];
         end else if (state_ff == ST_CREAD) begin
            hist_rd_ff[c] <= hist_mem[c][pix_ff[c]];
         end else begin
            hist_rd_ff[c] <= hist_mem[c][bin_ff];
         end
      end
   end

   // Mapping table memories; an empty histogram maps everything to zero.
   always_ff @(posedge clock) begin
      for (int c = 0; c < CHANNELS; c++) begin
         if (drsp.done && ch_ff == ChBits'(c)) begin
            map_mem[c][bin_ff] <= (total_ff == '0) ? 8'd0 : drsp.value;
         end
         if (accept) begin
            map_rd_ff[c] <= map_mem[c][(c < 3) ? in_pix[c] : 8'd0];
         end
      end
   end

   always_comb begin
      bread = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (ch_ff == ChBits'(c)) bread = hist_rd_ff[c];
      end
   end

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      bin_in   = bin_ff;
      ch_in    = ch_ff;
      cum_in   = cum_ff;
      dreq.start = 1'b0;
      dreq.cum   = cum_ff;
      dreq.total = 32'(total_ff);
      map_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (op_type'(req_operation))
                  OP_COUNT: state_in = ST_CREAD;
                  OP_MAP:   state_in = ST_MREAD;
                  OP_CLEAR: begin
                     state_in = ST_CLEAR;
                     bin_in   = '0;
                     total_in = '0;
                  end
                  OP_BUILD: begin
                     state_in = ST_BREAD;
                     bin_in   = '0;
                     ch_in    = '0;
                     cum_in   = '0;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CREAD: state_in = ST_CWR;
         ST_CWR: begin
            if (total_ff != CntMax) total_in = total_ff + 1'b1;
            state_in = ST_IDLE;
         end
         ST_MREAD: begin
            // Hold while the previous result still waits.
            if (!rsp_valid_ff || !rsp_stall) begin
               map_ready = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            bin_in = bin_ff + 1'b1;
            if (bin_ff == BinBits'(BinCount - 1)) state_in = ST_IDLE;
         end
         ST_BREAD: state_in = ST_BDIV;
         ST_BDIV: begin
            cum_in     = cum_ff + 40'(bread);
            dreq.cum   = cum_ff + 40'(bread);
            dreq.start = 1'b1;
            state_in   = ST_BWAIT;
         end
         ST_BWAIT: begin
            if (drsp.done) begin
               bin_in   = bin_ff + 1'b1;
               state_in = ST_BREAD;
               if (bin_ff == BinBits'(BinCount - 1)) begin
                  cum_in = '0;
                  if (ch_ff == ChBits'(CHANNELS - 1)) begin
                     state_in = ST_IDLE;
                  end else begin
                     ch_in = ch_ff + 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         total_ff     <= '0;
         bin_ff       <= '0;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         bin_ff   <= bin_in;
         ch_ff    <= ch_in;
         if (map_ready) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      cum_ff <= cum_in;
      if (accept) begin
         for (int c = 0; c < CHANNELS; c++) begin
            pix_ff[c] <= (c < 3) ? in_pix[c] : 8'd0;
         end
      end
      if (map_ready) begin
         for (int c = 0; c < 3; c++) begin
            out_ff[c] <= (c < CHANNELS) ? map_rd_ff[(c < CHANNELS) ? c : 0]
                                        : pass_ff[c];
         end
      end
   end

   // Pass-through value for channels without a table.
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int c = 0; c < 3; c++) pass_ff[c] <= in_pix[c];
      end
   end

   rhe_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_blue_out  = out_ff[0];
   assign rsp_green_out = out_ff[1];
   assign rsp_red_out   = out_ff[2];

   `RHE_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !accept)
   `RHE_ASSERT_NEXT(a_map_result, clock, reset, state_ff == ST_MREAD, rsp_valid)
   `RHE_ASSERT_IMP(a_div_only_build, clock, reset, drsp.done, state_ff == ST_BWAIT)
endmodule
